>>> rtl/modular_exponentiation_defines.svh
// assertion macros used by the checker file
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mexp_pkg.sv
// shared constants, codes and controller/datapath interface types
package mexp_pkg;

  // default widths of the configuration registers
  localparam int MOD_WIDTH_DEF = 31;
  localparam int EXP_WIDTH_DEF = 32;

  // fixed stream field widths
  localparam int VALUE_WIDTH = 31;
  localparam int POWER_WIDTH = 31;
  localparam int TDATA_WIDTH = 32;

  // configuration port
  localparam int CFG_INDEX_WIDTH = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 8'd1;
  localparam int MODULUS_RESET  = 3233;
  localparam int EXPONENT_RESET = 17;

  // operand selection for the modular multiplier
  localparam logic [1:0] OP_REDUCE = 2'd0;  // value * 1
  localparam logic [1:0] OP_MUL    = 2'd1;  // acc * sq
  localparam logic [1:0] OP_SQR    = 2'd2;  // sq * sq

  // commands from controller
  typedef struct packed {
    logic       item_load;
    logic       mul_start;
    logic [1:0] op_sel;
    logic       acc_load;
    logic       sq_load;
    logic       exp_clear0;
    logic       exp_shift;
    logic       res_load;
  } mexp_cmd_t;

  // status back to controller
  typedef struct packed {
    logic trivial;
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
  } mexp_status_t;

endpackage

>>> rtl/modular_exponentiation.sv
// modular exponentiation engine top level: config registers, output register
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata[30:0] value
//   out_     out  out_tvalid/out_tready out_tdata[30:0] power
//   cfg_     in   cfg_valid/cfg_ready   cfg_index (0 modulus, 1 exponent), cfg_data
//
// one word at a time; a word takes 1 + P + K modular multiplies, where
// P is the position of the highest set exponent bit and K the count of set
// bits, each modular multiply being 31 steps of the shared bit-serial unit.
// zero exponent or zero modulus skips the multiplies and goes straight to the result.
// synchronous active-low reset clears control state and loads 3233 and 17.
// a stalled result holds in the output register while the next word starts.
module modular_exponentiation #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
  localparam int CFG_DATA_WIDTH = (MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mexp_pkg::TDATA_WIDTH-1:0]     in_tdata,   // [30:0] value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mexp_pkg::TDATA_WIDTH-1:0]     out_tdata,  // [30:0] power
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]            cfg_data
);

  localparam int PW = mexp_pkg::POWER_WIDTH;
  localparam int TW = mexp_pkg::TDATA_WIDTH;

  logic [MOD_WIDTH-1:0]   modulus_r;
  logic [EXP_WIDTH-1:0]   exponent_r;
  logic                   out_valid_r;
  logic [PW-1:0]          out_power_r;
  logic                   out_free;
  logic [MOD_WIDTH-1:0]   result;
  mexp_pkg::mexp_cmd_t    cmd;
  mexp_pkg::mexp_status_t status;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
      exponent_r <= EXP_WIDTH'(mexp_pkg::EXPONENT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus_r  <= cfg_data[MOD_WIDTH-1:0];
        mexp_pkg::REG_EXPONENT: exponent_r <= cfg_data[EXP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_tdata[mexp_pkg::VALUE_WIDTH-1:0]),
    .cfg_modulus  (modulus_r),
    .cfg_exponent (exponent_r),
    .status       (status),
    .result       (result)
  );

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_power_r <= PW'(result);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TW'(out_power_r);

endmodule

>>> rtl/mexp_modmul.sv
// iterative interleaved modular multiplier, one multiplier bit per cycle
module mexp_modmul #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [mexp_pkg::VALUE_WIDTH-1:0]    a,
  input  logic [MOD_WIDTH-1:0]                b,
  input  logic [MOD_WIDTH-1:0]                m,
  output logic                                done,
  output logic [MOD_WIDTH-1:0]                r
);

  localparam int AW = mexp_pkg::VALUE_WIDTH;
  localparam int CW = $clog2(AW);
  localparam int RW = MOD_WIDTH + 2;

  logic [AW-1:0]        a_r;
  logic [MOD_WIDTH-1:0] b_r;
  logic [MOD_WIDTH-1:0] m_r;
  logic [MOD_WIDTH-1:0] r_r;
  logic [MOD_WIDTH-1:0] r_nxt;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [RW-1:0]        sum;
  logic [RW-1:0]        m1;
  logic [RW-1:0]        m2;

  // r = 2r + a_bit*b, then bring back below m (sum stays under 3m since b <= m)
  always_comb begin
    m1  = RW'(m_r);
    m2  = RW'({m_r, 1'b0});
    sum = RW'({r_r, 1'b0}) + (a_r[AW-1] ? RW'(b_r) : '0);
    if (sum >= m2) begin
      r_nxt = MOD_WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      r_nxt = MOD_WIDTH'(sum - m1);
    end else begin
      r_nxt = MOD_WIDTH'(sum);
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      r_r   <= '0;
      cnt_r <= CW'(AW - 1);
    end else if (busy_r) begin
      a_r   <= {a_r[AW-2:0], 1'b0};
      r_r   <= r_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // busy flag and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign r    = r_r;

endmodule

>>> rtl/mexp_datapath.sv
// accumulator, square and exponent registers around the shared multiplier
module mexp_datapath #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mexp_pkg::mexp_cmd_t              cmd,
  input  logic [mexp_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic [MOD_WIDTH-1:0]             cfg_modulus,
  input  logic [EXP_WIDTH-1:0]             cfg_exponent,
  output mexp_pkg::mexp_status_t           status,
  output logic [MOD_WIDTH-1:0]             result
);

  localparam int VW = mexp_pkg::VALUE_WIDTH;

  logic [MOD_WIDTH-1:0] acc_r;
  logic [MOD_WIDTH-1:0] sq_r;
  logic [EXP_WIDTH-1:0] exp_r;
  logic [VW-1:0]        op_a;
  logic [MOD_WIDTH-1:0] op_b;
  logic                 mul_done;
  logic [MOD_WIDTH-1:0] mul_r;
  logic                 mod_zero;
  logic                 cfg_exp_zero;

  assign mod_zero     = (cfg_modulus == '0);
  assign cfg_exp_zero = (cfg_exponent == '0);

  // multiplier operand select
  always_comb begin
    case (cmd.op_sel)
      mexp_pkg::OP_REDUCE: begin
        op_a = in_value;
        op_b = MOD_WIDTH'(1);
      end
      mexp_pkg::OP_MUL: begin
        op_a = VW'(acc_r);
        op_b = sq_r;
      end
      mexp_pkg::OP_SQR: begin
        op_a = VW'(sq_r);
        op_b = sq_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mexp_modmul #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (op_a),
    .b     (op_b),
    .m     (cfg_modulus),
    .done  (mul_done),
    .r     (mul_r)
  );

  // working registers; zero modulus or zero exponent ends the item at once
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      acc_r <= (mod_zero && !cfg_exp_zero) ? '0 : MOD_WIDTH'(1);
      exp_r <= mod_zero ? '0 : cfg_exponent;
    end else begin
      if (cmd.acc_load) begin
        acc_r <= mul_r;
      end
      if (cmd.exp_clear0) begin
        exp_r[0] <= 1'b0;
      end else if (cmd.exp_shift) begin
        exp_r <= exp_r >> 1;
      end
    end
    if (cmd.sq_load) begin
      sq_r <= mul_r;
    end
  end

  // status to controller
  always_comb begin
    status.trivial  = mod_zero || cfg_exp_zero;
    status.exp_zero = (exp_r == '0);
    status.exp_lsb  = exp_r[0];
    status.mul_done = mul_done;
  end

  assign result = acc_r;

endmodule

>>> rtl/mexp_ctrl.sv
// square-and-multiply sequencer
module mexp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   out_free,
  input  mexp_pkg::mexp_status_t status,
  output mexp_pkg::mexp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RED   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SQR   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op_sel = mexp_pkg::OP_REDUCE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.item_load = 1'b1;
          if (status.trivial) begin
            state_nxt = ST_CHECK;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.op_sel    = mexp_pkg::OP_REDUCE;
            state_nxt     = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (status.mul_done) begin
          cmd.sq_load = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.exp_zero) begin
          state_nxt = ST_DONE;
        end else if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.op_sel    = mexp_pkg::OP_MUL;
          state_nxt     = ST_MUL;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op_sel    = mexp_pkg::OP_SQR;
          state_nxt     = ST_SQR;
        end
      end
      ST_MUL: begin
        cmd.op_sel = mexp_pkg::OP_MUL;
        if (status.mul_done) begin
          cmd.acc_load   = 1'b1;
          cmd.exp_clear0 = 1'b1;
          state_nxt      = ST_CHECK;
        end
      end
      ST_SQR: begin
        cmd.op_sel = mexp_pkg::OP_SQR;
        if (status.mul_done) begin
          cmd.sq_load   = 1'b1;
          cmd.exp_shift = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/mexp_checker.sv
// port-level checks on the modular exponentiation engine, bound to the top
`include "modular_exponentiation_defines.svh"

module mexp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mexp_pkg::TDATA_WIDTH-1:0] out_tdata
);

  // a stalled result word holds
  `MEXP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // padding above the power field stays zero
  `MEXP_ASSERT_NOW(a_out_pad, out_tvalid, out_tdata[mexp_pkg::TDATA_WIDTH-1:mexp_pkg::POWER_WIDTH] == '0, "result padding not zero")

  // one word in flight: input closes right after an accept
  `MEXP_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input still open after accept")

  // no result appears in the cycle right after an accept
  `MEXP_ASSERT_NEXT(a_no_early, in_tvalid && in_tready, !$rose(out_tvalid), "result offered too early")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
